### rtl/priority_aging_job_scheduler_core_macros.svh
// Assertion macros for the priority aging job scheduler core.
// No dependencies; the top level includes this file.
`ifndef PRIORITY_AGING_JOB_SCHEDULER_CORE_MACROS_SVH
`define PRIORITY_AGING_JOB_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PAJS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pajs: same-cycle check failed");

// Next-cycle implication, off while in reset.
`define PAJS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pajs: next-cycle check failed");

`endif

### rtl/pajs_pkg.sv
// Shared types and constants for the priority aging job scheduler.
// No dependencies; used by the controller, the datapath and the top level.
package pajs_pkg;

    localparam int PRI_W     = 3;
    localparam int WAIT_W    = 8;
    localparam int AGE_W     = 8;
    localparam int FUNC_W    = 3;
    localparam int OUT_ID_W  = 16;
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Command codes
    localparam func_t FUNC_TICK = 3'd0;
    localparam func_t FUNC_ENQ  = 3'd1;
    localparam func_t FUNC_DEQ  = 3'd2;
    localparam func_t FUNC_NOP  = 3'd3;
    localparam func_t FUNC_MARK = 3'd4;

    // Register indexes
    localparam cfg_idx_t CFG_AGING = 1'b0;
    localparam cfg_idx_t CFG_CEIL  = 1'b1;

    localparam logic [WAIT_W-1:0] WAIT_MAX  = 8'hFF;
    localparam logic [AGE_W-1:0]  AGING_RST = 8'd10;
    localparam logic [PRI_W-1:0]  CEIL_RST  = 3'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture word, apply command
        logic scan_rd;   // read next slot
        logic finish;    // pick, switch, update counts
        logic wb;        // second slot write
        logic report;    // drive result ports
    } pajs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic no_tick;   // captured word is a finish mark
        logic scan_last; // reading the last slot
    } pajs_stat_t;

endpackage

### rtl/pajs_ctrl.sv
// Sequencing state machine for the priority aging job scheduler.
// Depends on pajs_pkg; drives the datapath through pajs_cmd_t.
module pajs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pajs_pkg::pajs_stat_t   stat,
    output pajs_pkg::pajs_cmd_t    cmd,
    output logic                   busy
);
    import pajs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_FIN,
        S_WB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.no_tick)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/pajs_dpath.sv
// Datapath of the priority aging job scheduler: slot memory, scan, pick, run state.
// Depends on pajs_pkg; commanded by pajs_ctrl.
module pajs_dpath #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pajs_pkg::pajs_cmd_t               cmd,
    output pajs_pkg::pajs_stat_t              stat,
    input  logic [pajs_pkg::FUNC_W-1:0]       func,
    input  logic [pajs_pkg::PRI_W-1:0]        base_priority,
    input  logic [pajs_pkg::OUT_ID_W-1:0]     target_id,
    input  logic                              cfg_we,
    input  logic [pajs_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [pajs_pkg::CFG_W-1:0]        cfg_wdata,
    output logic                              done,
    output logic                              running_valid,
    output logic [pajs_pkg::OUT_ID_W-1:0]     running_id,
    output logic                              switched,
    output logic [pajs_pkg::OUT_ID_W-1:0]     assigned_id,
    output logic                              rejected,
    output logic                              removed,
    output logic [pajs_pkg::CNT_W-1:0]        waiting_count
);
    import pajs_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int QLEN_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [PRI_W-1:0]   base;
        logic [PRI_W-1:0]   cur;
        logic [WAIT_W-1:0]  wait_cnt;
        logic [QLEN_W-1:0]  rank;
    } slot_t;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [PRI_W-1:0]   cur;
        logic [QLEN_W-1:0]  rank;
        logic [ID_BITS-1:0] id;
        logic [PRI_W-1:0]   base;
    } cand_t;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [QLEN_W-1:0]  rank;
    } hit_t;

    typedef struct packed {
        logic               vld;
        logic [QLEN_W-1:0]  rank;
    } pend_t;

    // slot memory: one write port, one registered read port
    slot_t mem [SLOTS];
    slot_t rd_data_reg;

    logic [SLOTS-1:0]    valid_reg;
    logic [QLEN_W-1:0]   queue_len_reg;
    logic                run_valid_reg;
    logic [ID_BITS-1:0]  run_id_reg;
    logic [PRI_W-1:0]    run_base_reg;
    logic                run_done_reg;
    logic [ID_BITS-1:0]  last_id_reg;
    logic [AGE_W-1:0]    aging_reg;
    logic [PRI_W-1:0]    ceil_reg;

    // per-word registers
    logic [FUNC_W-1:0]   func_reg;
    logic [PRI_W-1:0]    base_reg;
    logic [OUT_ID_W-1:0] target_reg;
    logic                new_reg;
    logic                deq_scan_reg;
    logic                switched_reg;
    logic                removed_reg;
    logic                rejected_reg;
    logic [OUT_ID_W-1:0] assigned_reg;

    // scan registers
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    proc_idx_reg;
    logic                proc_vld_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    cand_t               b1_reg;
    cand_t               b2_reg;
    hit_t                hit_reg;

    // rank fixes left by the last pick, applied as slots are read
    pend_t               pend_h_reg;
    pend_t               pend_s_reg;

    logic                wb_en_reg;
    slot_t               wb_data_reg;

    // result registers
    logic                done_reg;
    logic                out_run_valid_reg;
    logic [OUT_ID_W-1:0] out_run_id_reg;
    logic                out_switched_reg;
    logic [OUT_ID_W-1:0] out_assigned_reg;
    logic                out_rejected_reg;
    logic                out_removed_reg;
    logic [CNT_W-1:0]    out_count_reg;

    function automatic logic beats(
        input logic [PRI_W-1:0]  ca,
        input logic [QLEN_W-1:0] ra,
        input logic [PRI_W-1:0]  cb,
        input logic [QLEN_W-1:0] rb
    );
        return (ca > cb) || ((ca == cb) && (ra < rb));
    endfunction

    // ---- command side ----
    logic                run_match;
    logic [ID_BITS-1:0]  id_inc;
    logic [ID_BITS-1:0]  next_id;
    logic                full;

    always_comb
    begin
        run_match = (func == FUNC_DEQ) && run_valid_reg &&
                    (32'(run_id_reg) == 32'(target_id));
        id_inc    = last_id_reg + ID_BITS'(1);
        next_id   = (id_inc == '0) ? ID_BITS'(1) : id_inc;
        full      = (queue_len_reg == QLEN_W'(SLOTS));
    end

    // ---- scan side: age one slot ----
    logic                dec_h;
    logic                dec_s;
    logic [QLEN_W-1:0]   rank_c;
    logic [WAIT_W-1:0]   wait_n;
    logic [PRI_W-1:0]    cur_n;
    slot_t               aged;
    cand_t               cand_in;
    logic                id_hit;

    always_comb
    begin
        dec_h  = pend_h_reg.vld && (rd_data_reg.rank > pend_h_reg.rank);
        dec_s  = pend_s_reg.vld && (rd_data_reg.rank > pend_s_reg.rank);
        rank_c = rd_data_reg.rank - QLEN_W'(dec_h) - QLEN_W'(dec_s);
        wait_n = (rd_data_reg.wait_cnt == WAIT_MAX) ? WAIT_MAX
                                                    : rd_data_reg.wait_cnt + WAIT_W'(1);
        cur_n  = ((wait_n >= aging_reg) && (rd_data_reg.cur < ceil_reg))
                 ? rd_data_reg.cur + PRI_W'(1) : rd_data_reg.cur;

        aged.id       = rd_data_reg.id;
        aged.base     = rd_data_reg.base;
        aged.cur      = cur_n;
        aged.wait_cnt = wait_n;
        aged.rank     = rank_c;

        cand_in.vld  = 1'b1;
        cand_in.idx  = proc_idx_reg;
        cand_in.cur  = cur_n;
        cand_in.rank = rank_c;
        cand_in.id   = rd_data_reg.id;
        cand_in.base = rd_data_reg.base;

        id_hit = deq_scan_reg && (32'(rd_data_reg.id) == 32'(target_reg)) &&
                 (!hit_reg.vld || (rank_c < hit_reg.rank));
    end

    // ---- finish side: pick and switch ----
    cand_t               cand;
    logic [PRI_W-1:0]    new_cur;
    logic                sel_new;
    logic                sel_vld;
    logic                push;
    logic [ID_BITS-1:0]  sel_id;
    logic [PRI_W-1:0]    sel_base;
    logic [QLEN_W-1:0]   sel_rank;
    slot_t               push_ent;
    slot_t               new_ent;
    logic [QLEN_W-1:0]   q_next;

    always_comb
    begin
        // best slot left once the dequeued one is out
        cand    = (hit_reg.vld && (b1_reg.idx == hit_reg.idx)) ? b2_reg : b1_reg;
        new_cur = ((aging_reg <= AGE_W'(1)) && (base_reg < ceil_reg))
                  ? base_reg + PRI_W'(1) : base_reg;
        // the new job is youngest, so it needs a strictly higher priority
        sel_new = new_reg && (!cand.vld || (new_cur > cand.cur));
        sel_vld = cand.vld || new_reg;
        push    = sel_vld && run_valid_reg && !run_done_reg;

        sel_id   = sel_new ? last_id_reg   : cand.id;
        sel_base = sel_new ? base_reg      : cand.base;
        sel_rank = sel_new ? queue_len_reg : cand.rank;

        // ranks written in this word's numbering; the pending fixes settle them
        push_ent.id       = run_id_reg;
        push_ent.base     = run_base_reg;
        push_ent.cur      = run_base_reg;
        push_ent.wait_cnt = '0;
        push_ent.rank     = queue_len_reg + QLEN_W'(new_reg);

        new_ent.id        = last_id_reg;
        new_ent.base      = base_reg;
        new_ent.cur       = new_cur;
        new_ent.wait_cnt  = WAIT_W'(1);
        new_ent.rank      = queue_len_reg;

        q_next = queue_len_reg + QLEN_W'(new_reg) + QLEN_W'(push)
                 - QLEN_W'(hit_reg.vld) - QLEN_W'(sel_vld);
    end

    // ---- memory write port ----
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    slot_t               wr_data;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = proc_idx_reg;
        wr_data = aged;
        priority if (proc_vld_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.finish && push && !sel_new)
        begin
            wr_en   = 1'b1;
            wr_addr = cand.idx;
            wr_data = push_ent;
        end
        else if (cmd.wb && wb_en_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
            wr_data = wb_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            queue_len_reg     <= '0;
            run_valid_reg     <= 1'b0;
            run_id_reg        <= '0;
            run_base_reg      <= '0;
            run_done_reg      <= 1'b0;
            last_id_reg       <= '0;
            aging_reg         <= AGING_RST;
            ceil_reg          <= CEIL_RST;
            func_reg          <= FUNC_TICK;
            base_reg          <= '0;
            target_reg        <= '0;
            new_reg           <= 1'b0;
            deq_scan_reg      <= 1'b0;
            switched_reg      <= 1'b0;
            removed_reg       <= 1'b0;
            rejected_reg      <= 1'b0;
            assigned_reg      <= '0;
            scan_idx_reg      <= '0;
            proc_idx_reg      <= '0;
            proc_vld_reg      <= 1'b0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            b1_reg            <= '0;
            b2_reg            <= '0;
            hit_reg           <= '0;
            pend_h_reg        <= '0;
            pend_s_reg        <= '0;
            wb_en_reg         <= 1'b0;
            wb_data_reg       <= '0;
            done_reg          <= 1'b0;
            out_run_valid_reg <= 1'b0;
            out_run_id_reg    <= '0;
            out_switched_reg  <= 1'b0;
            out_assigned_reg  <= '0;
            out_rejected_reg  <= 1'b0;
            out_removed_reg   <= 1'b0;
            out_count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_AGING: aging_reg <= cfg_wdata;
                    CFG_CEIL:  ceil_reg  <= cfg_wdata[PRI_W-1:0];
                    default:   aging_reg <= aging_reg;
                endcase
            end

            // accept a word and apply its command
            if (cmd.load)
            begin
                func_reg       <= func;
                base_reg       <= base_priority;
                target_reg     <= target_id;
                switched_reg   <= 1'b0;
                removed_reg    <= run_match;
                rejected_reg   <= 1'b0;
                assigned_reg   <= '0;
                new_reg        <= 1'b0;
                deq_scan_reg   <= (func == FUNC_DEQ) && !run_match;
                scan_idx_reg   <= '0;
                free_found_reg <= 1'b0;
                b1_reg.vld     <= 1'b0;
                b2_reg.vld     <= 1'b0;
                hit_reg.vld    <= 1'b0;
                unique case (func)
                    FUNC_ENQ:
                    begin
                        if (full)
                        begin
                            rejected_reg <= 1'b1;
                        end
                        else
                        begin
                            new_reg      <= 1'b1;
                            last_id_reg  <= next_id;
                            assigned_reg <= OUT_ID_W'(next_id);
                        end
                    end
                    FUNC_DEQ:
                    begin
                        if (run_match)
                        begin
                            run_valid_reg <= 1'b0;
                            run_done_reg  <= 1'b0;
                        end
                    end
                    FUNC_MARK:
                    begin
                        if (run_valid_reg)
                        begin
                            run_done_reg <= 1'b1;
                        end
                    end
                    FUNC_TICK, FUNC_NOP:
                    begin
                        run_done_reg <= run_done_reg;
                    end
                    default:
                    begin
                        run_done_reg <= run_done_reg;
                    end
                endcase
            end

            // read stage
            if (cmd.scan_rd)
            begin
                proc_idx_reg <= scan_idx_reg;
                proc_vld_reg <= valid_reg[scan_idx_reg];
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (!valid_reg[scan_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= scan_idx_reg;
                end
            end
            else
            begin
                proc_vld_reg <= 1'b0;
            end

            // compare stage: keep the two best and the dequeue match
            if (proc_vld_reg)
            begin
                if (!b1_reg.vld || beats(cur_n, rank_c, b1_reg.cur, b1_reg.rank))
                begin
                    b2_reg <= b1_reg;
                    b1_reg <= cand_in;
                end
                else if (!b2_reg.vld || beats(cur_n, rank_c, b2_reg.cur, b2_reg.rank))
                begin
                    b2_reg <= cand_in;
                end
                if (id_hit)
                begin
                    hit_reg.vld  <= 1'b1;
                    hit_reg.idx  <= proc_idx_reg;
                    hit_reg.rank <= rank_c;
                end
            end

            if (cmd.finish)
            begin
                if (sel_vld)
                begin
                    run_valid_reg <= 1'b1;
                    run_id_reg    <= sel_id;
                    run_base_reg  <= sel_base;
                    run_done_reg  <= 1'b0;
                end
                else if (run_done_reg)
                begin
                    run_valid_reg <= 1'b0;
                    run_done_reg  <= 1'b0;
                end
                switched_reg    <= sel_vld;
                removed_reg     <= removed_reg | hit_reg.vld;
                queue_len_reg   <= q_next;
                pend_h_reg.vld  <= hit_reg.vld;
                pend_h_reg.rank <= hit_reg.rank;
                pend_s_reg.vld  <= sel_vld;
                pend_s_reg.rank <= sel_rank;

                if (hit_reg.vld)
                begin
                    valid_reg[hit_reg.idx] <= 1'b0;
                end
                if (sel_vld && !sel_new && !push)
                begin
                    valid_reg[cand.idx] <= 1'b0;
                end
                if ((new_reg && !sel_new) || (sel_new && push))
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    wb_en_reg               <= 1'b1;
                    wb_data_reg             <= sel_new ? push_ent : new_ent;
                end
                else
                begin
                    wb_en_reg <= 1'b0;
                end
            end

            if (cmd.report)
            begin
                done_reg          <= 1'b1;
                out_run_valid_reg <= run_valid_reg;
                out_run_id_reg    <= run_valid_reg ? OUT_ID_W'(run_id_reg) : '0;
                out_switched_reg  <= switched_reg;
                out_assigned_reg  <= assigned_reg;
                out_rejected_reg  <= rejected_reg;
                out_removed_reg   <= removed_reg;
                out_count_reg     <= CNT_W'(queue_len_reg);
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign stat.no_tick   = (func_reg == FUNC_MARK);
    assign stat.scan_last = (scan_idx_reg == IDX_W'(SLOTS - 1));

    assign done          = done_reg;
    assign running_valid = out_run_valid_reg;
    assign running_id    = out_run_id_reg;
    assign switched      = out_switched_reg;
    assign assigned_id   = out_assigned_reg;
    assign rejected      = out_rejected_reg;
    assign removed       = out_removed_reg;
    assign waiting_count = out_count_reg;

endmodule

### rtl/priority_aging_job_scheduler_core.sv
// Top level of the priority aging job scheduler: controller plus datapath.
// Depends on pajs_pkg, pajs_ctrl, pajs_dpath and the assertion macro header.
`include "priority_aging_job_scheduler_core_macros.svh"

// Preemptive priority scheduler with aging. A command word (func, base_priority,
// target_id) is taken at a clock edge where start is high and busy is low.
// Codes: 0 tick, 1 enqueue then tick, 2 dequeue then tick, 3 no-op then tick,
// 4 mark the running job finished (no tick); 5 to 7 act as a plain tick.
// Every word yields exactly one result word, shown for a single cycle with
// done high; the receiver cannot stall it, so capture it on that cycle.
// A ticking word scans the slot memory through its single read port one entry
// per clock; a finish mark skips the scan. No clearing pass is needed after
// reset: slot valid bits live in flops. Configuration (cfg_we, cfg_addr,
// cfg_wdata) is to be written by the user only while idle; the block itself
// does not enforce this. Index 0 is aging_ticks (reset 10), index 1 is
// priority_ceiling (reset 3).
module priority_aging_job_scheduler_core #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command word
    input  logic                              start,
    output logic                              busy,
    input  logic [pajs_pkg::FUNC_W-1:0]       func,
    input  logic [pajs_pkg::PRI_W-1:0]        base_priority,
    input  logic [pajs_pkg::OUT_ID_W-1:0]     target_id,
    // configuration
    input  logic                              cfg_we,
    input  logic [pajs_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [pajs_pkg::CFG_W-1:0]        cfg_wdata,
    // result word
    output logic                              done,
    output logic                              running_valid,
    output logic [pajs_pkg::OUT_ID_W-1:0]     running_id,
    output logic                              switched,
    output logic [pajs_pkg::OUT_ID_W-1:0]     assigned_id,
    output logic                              rejected,
    output logic                              removed,
    output logic [pajs_pkg::CNT_W-1:0]        waiting_count
);
    import pajs_pkg::*;

    pajs_cmd_t  cmd;
    pajs_stat_t stat;

    // Sequencer: idle, decode, slot scan, drain, pick, write-back.
    pajs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Slot memory, running job, id counter and the result register.
    // Ranks are fixed up lazily: the removals of one word are applied
    // to each slot as the next word's scan reads it.
    pajs_dpath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .base_priority (base_priority),
        .target_id     (target_id),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .running_valid (running_valid),
        .running_id    (running_id),
        .switched      (switched),
        .assigned_id   (assigned_id),
        .rejected      (rejected),
        .removed       (removed),
        .waiting_count (waiting_count)
    );

    // Result strobe lasts one cycle.
    `PAJS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // An accepted word makes the block busy and never reports on the next cycle.
    `PAJS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    // No running job means a zero id.
    `PAJS_ASSERT_NOW(a_idle_id, clk, rst_n, done && !running_valid, running_id == '0)
    // A rejected enqueue hands out no id and removes nothing.
    `PAJS_ASSERT_NOW(a_reject_clean, clk, rst_n, done && rejected, (assigned_id == '0) && !removed)

endmodule
